>>> hdl/lsld_pkg.sv
// Shared types, widths and constants for the light sensor LED dimmer.
package lsld_pkg;

  localparam int unsigned RawW     = 12;
  localparam int unsigned ElapsedW = 10;
  localparam int unsigned DebW     = 10;
  localparam int unsigned StepW    = 6;
  localparam int unsigned PctW     = 7;
  localparam int unsigned DutyW    = 13;
  localparam int unsigned CountW   = 11;
  localparam int unsigned NumW     = 22;
  localparam int unsigned RecipW   = 23;
  localparam int unsigned ProdW    = NumW + RecipW;
  localparam int unsigned RecipShift = 31;

  localparam logic [RawW-1:0]   OffMaxRaw = 12'd2457;
  localparam logic [RawW-1:0]   MidMaxRaw = 12'd2662;
  localparam logic [15:0]       RawOffset = 16'd26624;
  localparam logic [CountW-1:0] CountMax  = 11'd2047;
  localparam logic [PctW-1:0]   PctMax    = 7'd100;
  localparam logic [PctW-1:0]   PctMin    = 7'd1;
  // ceil(2^31 / 350) + 1
  localparam logic [RecipW-1:0] Recip350  = 23'd6135669;

  localparam logic [DebW-1:0]  DebounceRst = 10'd20;
  localparam logic [StepW-1:0] StepRst     = 6'd10;
  localparam logic [PctW-1:0]  FloorRst    = 7'd1;

  typedef enum logic [1:0] {
    RegDebounce = 2'd0,
    RegStep     = 2'd1,
    RegFloor    = 2'd2
  } cfg_reg_e;

  typedef struct packed {
    logic              waiting;
    logic [CountW-1:0] count;
  } btn_state_t;

endpackage

>>> hdl/lsld_btn.sv
// Button debounce timer: arms on a pin change, acts on a low level after the hold time.
module lsld_btn (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       accept_i,
  input  logic [lsld_pkg::DebW-1:0]  debounce_i,
  input  logic [lsld_pkg::ElapsedW-1:0] elapsed_i,
  input  logic                       level_i,
  input  logic                       changed_i,
  output logic                       act_o,
  output lsld_pkg::btn_state_t       state_o
);
  import lsld_pkg::*;

  btn_state_t         st_q, st_d;
  logic [CountW:0]    sum;
  logic [CountW-1:0]  sat;

  always_comb begin
    sum   = {1'b0, st_q.count} + (CountW+1)'(elapsed_i);
    sat   = (sum > (CountW+1)'(CountMax)) ? CountMax : sum[CountW-1:0];
    st_d  = st_q;
    act_o = 1'b0;
    if (changed_i) begin
      // a change rearms and clears the timer in the same word
      st_d.waiting = 1'b1;
      st_d.count   = '0;
    end else if (st_q.waiting) begin
      st_d.count = sat;
      if (sat > CountW'(debounce_i)) begin
        st_d.waiting = 1'b0;
        act_o        = ~level_i;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q <= '0;
    end else if (accept_i) begin
      st_q <= st_d;
    end
  end

  assign state_o = st_q;

endmodule

>>> hdl/lsld_duty.sv
// Duty pipeline: numerator stage, then reciprocal multiply for the divide by 350.
module lsld_duty (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      in_valid_i,
  output logic                      in_ready_o,
  input  logic [lsld_pkg::RawW-1:0] raw_i,
  input  logic [lsld_pkg::PctW-1:0] pct_i,
  output logic                      out_valid_o,
  input  logic                      out_ready_i,
  output logic [lsld_pkg::DutyW-1:0] duty_o,
  output logic [lsld_pkg::PctW-1:0] pct_o
);
  import lsld_pkg::*;

  logic              v2_q, v3_q;
  logic              rdy2, rdy3;
  logic [NumW-1:0]   n_q, n_d;
  logic              zero_q;
  logic [PctW-1:0]   p2_q, p3_q;
  logic [DutyW-1:0]  duty_q, duty_d;
  logic [15:0]       raw10;
  logic [15:0]       diff;
  logic [PctW-1:0]   inv;
  logic [20:0]       mix;
  logic [NumW-1:0]   base;
  logic [ProdW-1:0]  quot;

  assign rdy3       = ~v3_q | out_ready_i;
  assign rdy2       = ~v2_q | rdy3;
  assign in_ready_o = rdy2;

  // 14336p/350 equals 1024p/25, so both lit branches share the divider
  always_comb begin
    raw10 = (16'(raw_i) << 3) + (16'(raw_i) << 1);
    diff  = raw10 - RawOffset;
    inv   = PctMax - pct_i;
    mix   = diff[13:0] * inv;
    base  = (NumW'(pct_i) << 13) + (NumW'(pct_i) << 12) + (NumW'(pct_i) << 11);
    n_d   = (raw_i > MidMaxRaw) ? base + NumW'(mix) : base;
  end

  always_comb begin
    quot   = ProdW'(n_q) * ProdW'(Recip350);
    duty_d = zero_q ? '0 : quot[RecipShift +: DutyW];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v2_q <= 1'b0;
      v3_q <= 1'b0;
    end else begin
      if (rdy2) v2_q <= in_valid_i;
      if (rdy3) v3_q <= v2_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (rdy2 && in_valid_i) begin
      n_q    <= n_d;
      zero_q <= (raw_i <= OffMaxRaw);
      p2_q   <= pct_i;
    end
    if (rdy3 && v2_q) begin
      duty_q <= duty_d;
      p3_q   <= p2_q;
    end
  end

  assign out_valid_o = v3_q;
  assign duty_o      = duty_q;
  assign pct_o       = p3_q;

endmodule

>>> hdl/light_sensor_led_dimmer_top.sv
// Light sensor LED dimmer: button debounce, base brightness and PWM duty.
//
// Input words arrive on s_axis, one word per sensor sample with elapsed time
// and both button pins. Each word gives exactly one output word on m_axis:
// duty on a 4096-count PWM period and the current base percent.
// A word is taken every cycle while the pipe has room; from accept to
// m_axis_tvalid it passes the state/percent, numerator and reciprocal
// divide stages. Throughput is one word per cycle with m_axis_tready high.
// Button state and base offset update on the accept edge, so the next word
// already sees the new percent.
// If m_axis_tready stays low, the pipe fills; s_axis_tready drops once all
// three stages hold words, and nothing is lost or repeated.
// Registers on the APB port: 0x0 debounce ms, 0x4 step percent,
// 0x8 floor percent. Write them only while the pipe is empty.
// Reset clears the pipe, the button timers and the base offset, and loads
// debounce 20 ms, step 10 and floor 1.
module light_sensor_led_dimmer_top (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  // [11:0] light_raw, [21:12] elapsed_ms, [22] up_level, [23] down_level,
  // [24] up_changed, [25] down_changed, [31:26] zero
  input  logic [31:0] s_axis_tdata,
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  // [12:0] duty, [19:13] base_percent, [23:20] zero
  output logic [23:0] m_axis_tdata,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [3:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);
  import lsld_pkg::*;

  logic [DebW-1:0]     deb_q;
  logic [StepW-1:0]    step_q;
  logic [PctW-1:0]     floor_q;
  logic                cfg_wr;
  cfg_reg_e            cfg_sel;

  logic [RawW-1:0]     raw_in;
  logic [ElapsedW-1:0] elapsed_in;
  logic                accept;
  logic                up_act, dn_act;
  btn_state_t          up_st, dn_st;

  logic [PctW-1:0]     off_q, off_d, off_a;
  logic [8:0]          sum_up;
  logic [7:0]          psum;
  logic [PctW-1:0]     pct_d;

  logic                v1_q, ready1, rdy_duty;
  logic [RawW-1:0]     raw1_q;
  logic [PctW-1:0]     p1_q;
  logic [DutyW-1:0]    duty_out;
  logic [PctW-1:0]     pct_out;

  // configuration port
  assign pready  = 1'b1;
  assign cfg_wr  = psel & penable & pwrite & pready;
  assign cfg_sel = cfg_reg_e'(paddr[3:2]);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      deb_q   <= DebounceRst;
      step_q  <= StepRst;
      floor_q <= FloorRst;
    end else if (cfg_wr) begin
      case (cfg_sel)
        RegDebounce: deb_q   <= pwdata[DebW-1:0];
        RegStep:     step_q  <= pwdata[StepW-1:0];
        RegFloor:    floor_q <= pwdata[PctW-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (cfg_sel)
      RegDebounce: prdata = 32'(deb_q);
      RegStep:     prdata = 32'(step_q);
      RegFloor:    prdata = 32'(floor_q);
      default:     prdata = '0;
    endcase
  end

  // input side
  assign raw_in     = s_axis_tdata[11:0];
  assign elapsed_in = s_axis_tdata[21:12];
  assign accept     = s_axis_tvalid & s_axis_tready;
  assign ready1     = ~v1_q | rdy_duty;
  assign s_axis_tready = ready1;

  lsld_btn u_btn_up (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .accept_i   (accept),
    .debounce_i (deb_q),
    .elapsed_i  (elapsed_in),
    .level_i    (s_axis_tdata[22]),
    .changed_i  (s_axis_tdata[24]),
    .act_o      (up_act),
    .state_o    (up_st)
  );

  lsld_btn u_btn_dn (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .accept_i   (accept),
    .debounce_i (deb_q),
    .elapsed_i  (elapsed_in),
    .level_i    (s_axis_tdata[23]),
    .changed_i  (s_axis_tdata[25]),
    .act_o      (dn_act),
    .state_o    (dn_st)
  );

  // up press first, then down press on the updated offset
  always_comb begin
    sum_up = 9'(floor_q) + 9'(off_q) + 9'(step_q);
    off_a  = (up_act && sum_up <= 9'(PctMax)) ? off_q + PctW'(step_q) : off_q;
    off_d  = (dn_act && off_a >= PctW'(step_q)) ? off_a - PctW'(step_q) : off_a;
    psum   = 8'(floor_q) + 8'(off_d);
    if (psum < 8'(PctMin)) begin
      pct_d = PctMin;
    end else if (psum > 8'(PctMax)) begin
      pct_d = PctMax;
    end else begin
      pct_d = psum[PctW-1:0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      off_q <= '0;
      v1_q  <= 1'b0;
    end else begin
      if (accept) off_q <= off_d;
      if (ready1) v1_q <= s_axis_tvalid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      raw1_q <= raw_in;
      p1_q   <= pct_d;
    end
  end

  lsld_duty u_duty (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (v1_q),
    .in_ready_o  (rdy_duty),
    .raw_i       (raw1_q),
    .pct_i       (p1_q),
    .out_valid_o (m_axis_tvalid),
    .out_ready_i (m_axis_tready),
    .duty_o      (duty_out),
    .pct_o       (pct_out)
  );

  assign m_axis_tdata = {4'b0, pct_out, duty_out};

  a_accept_loads: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept |=> v1_q)
    else $error("accepted word not captured");

  a_pct_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    v1_q |-> (p1_q >= PctMin && p1_q <= PctMax))
    else $error("base percent out of range");

  a_stage1_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (v1_q && !ready1) |=> (v1_q && $stable(p1_q) && $stable(raw1_q)))
    else $error("stalled stage lost its word");

  a_duty_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> (duty_out <= 13'd4096))
    else $error("duty above period");

  a_btn_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (up_act || dn_act) |-> (up_st.waiting || dn_st.waiting))
    else $error("button acted while not armed");

endmodule

>>> test/lsld_monitor.sv
// Channel monitor for the dimmer: predicts each output word and compares it.
`timescale 1ns / 1ps

module lsld_monitor (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  input  logic        s_axis_tready,
  input  logic [31:0] s_axis_tdata,
  input  logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  input  logic [23:0] m_axis_tdata,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [3:0]  paddr,
  input  logic [31:0] pwdata,
  input  logic        pready,
  output int          mismatches,
  output int          in_flight
);
  import lsld_pkg::*;

  localparam int BtnUp = 0;
  localparam int BtnDn = 1;

  typedef struct packed {
    logic                down_changed;
    logic                up_changed;
    logic                down_level;
    logic                up_level;
    logic [ElapsedW-1:0] elapsed_ms;
    logic [RawW-1:0]     light_raw;
  } sample_t;

  typedef struct packed {
    logic [PctW-1:0]  base_percent;
    logic [DutyW-1:0] duty;
  } dim_out_t;

  logic [DebW-1:0]  deb_ms;
  logic [StepW-1:0] step_pct;
  logic [PctW-1:0]  floor_pct;
  logic [PctW-1:0]  offset_pct;
  bit               btn_wait [2];
  bit               btn_pend [2];
  int unsigned      btn_ms   [2];

  dim_out_t duty_q [$];
  dim_out_t got, want;

  function automatic bit btn_fires(int b, int unsigned el, logic lv);
    if (!btn_wait[b]) return 1'b0;
    if (btn_pend[b]) begin
      btn_ms[b]   = 0;
      btn_pend[b] = 1'b0;
      return 1'b0;
    end
    btn_ms[b] = btn_ms[b] + el;
    if (btn_ms[b] > CountMax) btn_ms[b] = CountMax;
    if (btn_ms[b] > deb_ms) begin
      btn_wait[b] = 1'b0;
      return lv == 1'b0;
    end
    return 1'b0;
  endfunction

  function automatic dim_out_t next_dim_output(sample_t s);
    int unsigned p;
    int unsigned raw;
    dim_out_t r;
    if (s.up_changed) begin
      btn_pend[BtnUp] = 1'b1;
      btn_wait[BtnUp] = 1'b1;
    end
    if (s.down_changed) begin
      btn_pend[BtnDn] = 1'b1;
      btn_wait[BtnDn] = 1'b1;
    end
    if (btn_fires(BtnUp, s.elapsed_ms, s.up_level)) begin
      if (floor_pct + offset_pct + step_pct <= 100) offset_pct = PctW'(offset_pct + step_pct);
    end
    if (btn_fires(BtnDn, s.elapsed_ms, s.down_level)) begin
      if (offset_pct >= step_pct) offset_pct = offset_pct - step_pct;
    end
    p = floor_pct + offset_pct;
    if (p < 1) p = 1;
    if (p > 100) p = 100;
    raw = s.light_raw;
    r.base_percent = PctW'(p);
    if (raw <= 2457) r.duty = '0;
    else if (raw <= 2662) r.duty = DutyW'((1024 * p) / 25);
    else r.duty = DutyW'((14336 * p + (10 * raw - 26624) * (100 - p)) / 350);
    return r;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      deb_ms     = DebounceRst;
      step_pct   = StepRst;
      floor_pct  = FloorRst;
      offset_pct = '0;
      for (int b = 0; b < 2; b++) begin
        btn_wait[b] = 1'b0;
        btn_pend[b] = 1'b0;
        btn_ms[b]   = 0;
      end
      duty_q.delete();
      mismatches = 0;
      in_flight  = 0;
    end else begin
      if (psel && penable && pwrite && pready) begin
        case (cfg_reg_e'(paddr[3:2]))
          RegDebounce: deb_ms    = pwdata[DebW-1:0];
          RegStep:     step_pct  = pwdata[StepW-1:0];
          RegFloor:    floor_pct = pwdata[PctW-1:0];
          default: ;
        endcase
      end
      if (s_axis_tvalid && s_axis_tready) begin
        duty_q.push_back(next_dim_output(sample_t'(s_axis_tdata[25:0])));
      end
      if (m_axis_tvalid && m_axis_tready) begin
        got = dim_out_t'(m_axis_tdata[19:0]);
        if (duty_q.size() == 0) begin
          mismatches++;
          $display("%0t: unexpected word, expected none, actual duty %0d percent %0d",
                   $time, got.duty, got.base_percent);
        end else begin
          want = duty_q.pop_front();
          if (got.duty !== want.duty) begin
            mismatches++;
            $display("%0t: duty mismatch, expected %0d, actual %0d",
                     $time, want.duty, got.duty);
          end
          if (got.base_percent !== want.base_percent) begin
            mismatches++;
            $display("%0t: base percent mismatch, expected %0d, actual %0d",
                     $time, want.base_percent, got.base_percent);
          end
        end
      end
      in_flight = duty_q.size();
    end
  end

endmodule

>>> test/tb_light_sensor_led_dimmer_top.sv
// Top-level bench for the dimmer: clock, reset, stimulus, stalls and verdict.
`timescale 1ns / 1ps

module tb_light_sensor_led_dimmer_top;
  import lsld_pkg::*;

  localparam int CycleLimit    = 400000;
  localparam int ItemsPerPhase = 275;
  localparam int HoldCycles    = 300;
  localparam int NumPhases     = 7;

  logic        clk_i;
  logic        rst_ni;
  logic        s_axis_tvalid;
  logic        s_axis_tready;
  logic [31:0] s_axis_tdata;
  logic        m_axis_tvalid;
  logic        m_axis_tready;
  logic [23:0] m_axis_tdata;
  logic        psel;
  logic        penable;
  logic        pwrite;
  logic [3:0]  paddr;
  logic [31:0] pwdata;
  logic [31:0] prdata;
  logic        pready;

  int mismatches;
  int in_flight;
  int cyc;
  int hold_left;
  bit calm;
  bit hold_go;
  bit hold_done;
  bit up_pin;
  bit dn_pin;

  // phase 0 keeps reset values; the last phase is drawn at random
  int unsigned ph_deb   [NumPhases] = '{20, 0, 1023, 7, 30, 15, 0};
  int unsigned ph_step  [NumPhases] = '{10, 1, 50, 63, 0, 25, 0};
  int unsigned ph_floor [NumPhases] = '{1, 1, 100, 0, 127, 40, 0};

  light_sensor_led_dimmer_top dut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata),
    .psel         (psel),
    .penable      (penable),
    .pwrite       (pwrite),
    .paddr        (paddr),
    .pwdata       (pwdata),
    .prdata       (prdata),
    .pready       (pready)
  );

  lsld_monitor u_monitor (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata),
    .psel         (psel),
    .penable      (penable),
    .pwrite       (pwrite),
    .paddr        (paddr),
    .pwdata       (pwdata),
    .pready       (pready),
    .mismatches   (mismatches),
    .in_flight    (in_flight)
  );

  initial begin
    clk_i = 1'b0;
    forever #2 clk_i = ~clk_i;
  end

  initial begin
    cyc = 0;
    forever begin
      @(posedge clk_i);
      cyc++;
      if (cyc > CycleLimit) begin
        $display("TB_ERROR");
        $finish;
      end
    end
  end

  // output side: random stalls, one long hold-off on request
  initial begin
    m_axis_tready = 1'b0;
    hold_left     = 0;
    hold_done     = 1'b0;
    forever begin
      @(negedge clk_i);
      if (hold_go && !hold_done) begin
        hold_done = 1'b1;
        hold_left = HoldCycles;
      end
      if (hold_left > 0) begin
        hold_left--;
        m_axis_tready = 1'b0;
      end else begin
        m_axis_tready = calm || ($urandom_range(0, 99) >= 26);
      end
    end
  end

  task automatic send_sample(int unsigned raw, int unsigned el, bit ul, bit dl, bit uc, bit dc);
    if (!calm) begin
      while ($urandom_range(0, 99) < 26) begin
        s_axis_tvalid = 1'b0;
        @(negedge clk_i);
      end
    end
    s_axis_tvalid = 1'b1;
    s_axis_tdata  = {6'b0, dc, uc, dl, ul, ElapsedW'(el), RawW'(raw)};
    // ready is settled in the low phase; the word goes at the next rising edge
    #1;
    while (!s_axis_tready) begin
      @(negedge clk_i);
      #1;
    end
    @(posedge clk_i);
    @(negedge clk_i);
  endtask

  task automatic random_sample();
    int unsigned raw;
    int unsigned el;
    int unsigned k;
    bit uc;
    bit dc;
    k = $urandom_range(0, 9);
    if (k < 3) raw = $urandom_range(0, 2457);
    else if (k < 5) raw = $urandom_range(2458, 2662);
    else if (k < 9) raw = $urandom_range(2663, 4095);
    else begin
      case ($urandom_range(0, 5))
        0: raw = 0;
        1: raw = 2457;
        2: raw = 2458;
        3: raw = 2662;
        4: raw = 2663;
        default: raw = 4095;
      endcase
    end
    k = $urandom_range(0, 9);
    if (k < 7) el = $urandom_range(0, 30);
    else if (k < 9) el = $urandom_range(0, 1023);
    else el = $urandom_range(0, 1) ? 1023 : 0;
    // press, hold and release: toggles are rare so levels settle
    k = $urandom_range(0, 99);
    if (k < 12) up_pin = ~up_pin;
    uc = (k < 15);
    k = $urandom_range(0, 99);
    if (k < 12) dn_pin = ~dn_pin;
    dc = (k < 15);
    send_sample(raw, el, up_pin, dn_pin, uc, dc);
  endtask

  task automatic apb_write(cfg_reg_e r, logic [31:0] v);
    psel    = 1'b1;
    penable = 1'b0;
    pwrite  = 1'b1;
    paddr   = {r, 2'b00};
    pwdata  = v;
    @(negedge clk_i);
    penable = 1'b1;
    @(posedge clk_i);
    while (!pready) @(posedge clk_i);
    @(negedge clk_i);
    psel    = 1'b0;
    penable = 1'b0;
    pwrite  = 1'b0;
  endtask

  task automatic drain();
    s_axis_tvalid = 1'b0;
    while (in_flight != 0) @(negedge clk_i);
    repeat (4) @(negedge clk_i);
  endtask

  initial begin
    rst_ni        = 1'b0;
    s_axis_tvalid = 1'b0;
    s_axis_tdata  = '0;
    psel          = 1'b0;
    penable       = 1'b0;
    pwrite        = 1'b0;
    paddr         = '0;
    pwdata        = '0;
    calm          = 1'b0;
    hold_go       = 1'b0;
    up_pin        = 1'b1;
    dn_pin        = 1'b1;
    repeat (7) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);

    // band edges and extreme fields
    send_sample(0, 0, 1, 1, 0, 0);
    send_sample(2457, 5, 1, 1, 0, 0);
    send_sample(2458, 5, 1, 1, 0, 0);
    send_sample(2662, 5, 1, 1, 0, 0);
    send_sample(2663, 5, 1, 1, 0, 0);
    send_sample(4095, 1023, 1, 1, 0, 0);
    // up press: arm, count, fire past debounce
    send_sample(3000, 3, 0, 1, 1, 0);
    send_sample(3000, 10, 0, 1, 0, 0);
    send_sample(3000, 11, 0, 1, 0, 0);
    // down wait ends on a high level, no step
    send_sample(3500, 0, 1, 1, 0, 1);
    send_sample(3500, 1023, 1, 1, 0, 0);
    // both buttons in one word, up handled first
    send_sample(4000, 0, 0, 0, 1, 1);
    send_sample(4000, 25, 0, 0, 0, 0);
    // down to zero offset, then a refused decrease
    send_sample(2500, 0, 1, 0, 0, 1);
    send_sample(2500, 30, 1, 0, 0, 0);
    send_sample(2500, 0, 1, 0, 0, 1);
    send_sample(2500, 30, 1, 0, 0, 0);
    // change during the wait re-arms and clears the timer
    send_sample(2600, 15, 0, 1, 1, 0);
    send_sample(2600, 15, 0, 1, 0, 0);
    send_sample(2600, 0, 0, 1, 1, 0);
    send_sample(2600, 15, 0, 1, 0, 0);
    send_sample(2600, 10, 0, 1, 0, 0);
    send_sample(3100, 0, 1, 1, 1, 1);
    send_sample(3100, 40, 1, 1, 0, 0);

    for (int ph = 0; ph < NumPhases; ph++) begin
      if (ph > 0) begin
        drain();
        if (ph == NumPhases - 1) begin
          ph_deb[ph]   = $urandom_range(0, 60);
          ph_step[ph]  = $urandom_range(1, 50);
          ph_floor[ph] = $urandom_range(1, 100);
        end
        apb_write(RegDebounce, ph_deb[ph]);
        apb_write(RegStep, ph_step[ph]);
        apb_write(RegFloor, ph_floor[ph]);
      end
      calm    = (ph == 1);
      hold_go = (ph == 5);
      for (int i = 0; i < ItemsPerPhase; i++) random_sample();
    end

    s_axis_tvalid = 1'b0;
    while (in_flight != 0) @(negedge clk_i);
    repeat (10) @(negedge clk_i);
    if (mismatches == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule
